// File: sv/isp65_pkg.sv
`default_nettype none
package isp65_pkg;

  typedef enum logic [6:0] {
    MN_ADC, MN_AND, MN_ASL, MN_BCC, MN_BCS, MN_BEQ, MN_BIT, MN_BMI, MN_BNE, MN_BPL, MN_BRA,
    MN_BRK, MN_BVC, MN_BVS, MN_CLC, MN_CLD, MN_CLI, MN_CLV, MN_CMP, MN_CPX, MN_CPY, MN_DEC,
    MN_DEX, MN_DEY, MN_EOR, MN_INC, MN_INX, MN_INY, MN_JMP, MN_JSR, MN_LDA, MN_LDX, MN_LDY,
    MN_LSR, MN_NOP, MN_ORA, MN_PHA, MN_PHP, MN_PHX, MN_PHY, MN_PLA, MN_PLP, MN_PLX, MN_PLY,
    MN_ROL, MN_ROR, MN_RTI, MN_RTS, MN_SBC, MN_SEC, MN_SED, MN_SEI, MN_STA, MN_STP, MN_STX,
    MN_STY, MN_STZ, MN_TAX, MN_TAY, MN_TRB, MN_TSB, MN_TSX, MN_TXA, MN_TXS, MN_TYA, MN_WAI,
    MN_UND
  } mnem_e;

  typedef enum logic [3:0] {
    AM_IMP, AM_ACC, AM_REL, AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_ZIX, AM_ZIY, AM_ZI,
    AM_AB, AM_ABX, AM_ABY, AM_AI, AM_AIX
  } mode_e;

  localparam logic [15:0] BranchBias = 16'd2;

  typedef struct packed {
    logic [7:0] code_byte;
  } in_word_t;

  typedef struct packed {
    logic [15:0] instr_address;
    logic [7:0]  opcode;
    logic [6:0]  mnemonic;
    logic [3:0]  addr_mode;
    logic [7:0]  operand_low;
    logic [7:0]  operand_high;
    logic [1:0]  instr_length;
    logic [15:0] branch_target;
  } out_word_t;

  typedef struct packed {
    mnem_e mnem;
    mode_e mode;
  } op_info_t;

  function automatic logic [1:0] mode_length(mode_e m);
    logic [1:0] len;
    unique case (m) inside
      AM_IMP, AM_ACC: len = 2'd1;
      AM_REL, AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_ZIX, AM_ZIY, AM_ZI: len = 2'd2;
      default: len = 2'd3;
    endcase
    return len;
  endfunction

  function automatic op_info_t op_lookup(logic [7:0] op);
    op_info_t r;
    r = '{mnem: MN_UND, mode: AM_IMP};
    unique case (op)
      8'h00: r = '{MN_BRK, AM_IMP}; 8'h01: r = '{MN_ORA, AM_ZIX};
      8'h04: r = '{MN_TSB, AM_ZP};  8'h05: r = '{MN_ORA, AM_ZP};
      8'h06: r = '{MN_ASL, AM_ZP};  8'h08: r = '{MN_PHP, AM_IMP};
      8'h09: r = '{MN_ORA, AM_IMM}; 8'h0A: r = '{MN_ASL, AM_ACC};
      8'h0C: r = '{MN_TSB, AM_AB};  8'h0D: r = '{MN_ORA, AM_AB};
      8'h0E: r = '{MN_ASL, AM_AB};
      8'h10: r = '{MN_BPL, AM_REL}; 8'h11: r = '{MN_ORA, AM_ZIY};
      8'h12: r = '{MN_ORA, AM_ZI};  8'h14: r = '{MN_TRB, AM_ZP};
      8'h15: r = '{MN_ORA, AM_ZPX}; 8'h16: r = '{MN_ASL, AM_ZPX};
      8'h18: r = '{MN_CLC, AM_IMP}; 8'h19: r = '{MN_ORA, AM_ABY};
      8'h1A: r = '{MN_INC, AM_ACC}; 8'h1C: r = '{MN_TRB, AM_AB};
      8'h1D: r = '{MN_ORA, AM_ABX}; 8'h1E: r = '{MN_ASL, AM_ABX};
      8'h20: r = '{MN_JSR, AM_AB};  8'h21: r = '{MN_AND, AM_ZIX};
      8'h24: r = '{MN_BIT, AM_ZP};  8'h25: r = '{MN_AND, AM_ZP};
      8'h26: r = '{MN_ROL, AM_ZP};  8'h28: r = '{MN_PLP, AM_IMP};
      8'h29: r = '{MN_AND, AM_IMM}; 8'h2A: r = '{MN_ROL, AM_ACC};
      8'h2C: r = '{MN_BIT, AM_AB};  8'h2D: r = '{MN_AND, AM_AB};
      8'h2E: r = '{MN_ROL, AM_AB};
      8'h30: r = '{MN_BMI, AM_REL}; 8'h31: r = '{MN_AND, AM_ZIY};
      8'h32: r = '{MN_AND, AM_ZI};  8'h34: r = '{MN_BIT, AM_ZPX};
      8'h35: r = '{MN_AND, AM_ZPX}; 8'h36: r = '{MN_ROL, AM_ZPX};
      8'h38: r = '{MN_SEC, AM_IMP}; 8'h39: r = '{MN_AND, AM_ABY};
      8'h3A: r = '{MN_DEC, AM_ACC}; 8'h3C: r = '{MN_BIT, AM_ABX};
      8'h3D: r = '{MN_AND, AM_ABX}; 8'h3E: r = '{MN_ROL, AM_ABX};
      8'h40: r = '{MN_RTI, AM_IMP}; 8'h41: r = '{MN_EOR, AM_ZIX};
      8'h44: r = '{MN_UND, AM_ZP};  8'h45: r = '{MN_EOR, AM_ZP};
      8'h46: r = '{MN_LSR, AM_ZP};  8'h48: r = '{MN_PHA, AM_IMP};
      8'h49: r = '{MN_EOR, AM_IMM}; 8'h4A: r = '{MN_LSR, AM_ACC};
      8'h4C: r = '{MN_JMP, AM_AB};  8'h4D: r = '{MN_EOR, AM_AB};
      8'h4E: r = '{MN_LSR, AM_AB};
      8'h50: r = '{MN_BVC, AM_REL}; 8'h51: r = '{MN_EOR, AM_ZIY};
      8'h52: r = '{MN_EOR, AM_ZI};  8'h54: r = '{MN_UND, AM_ZP};
      8'h55: r = '{MN_EOR, AM_ZPX}; 8'h56: r = '{MN_LSR, AM_ZPX};
      8'h58: r = '{MN_CLI, AM_IMP}; 8'h59: r = '{MN_EOR, AM_ABY};
      8'h5A: r = '{MN_PHY, AM_IMP}; 8'h5C: r = '{MN_UND, AM_AB};
      8'h5D: r = '{MN_EOR, AM_ABX}; 8'h5E: r = '{MN_LSR, AM_ABX};
      8'h60: r = '{MN_RTS, AM_IMP}; 8'h61: r = '{MN_ADC, AM_ZIX};
      8'h64: r = '{MN_STZ, AM_ZP};  8'h65: r = '{MN_ADC, AM_ZP};
      8'h66: r = '{MN_ROR, AM_ZP};  8'h68: r = '{MN_PLA, AM_IMP};
      8'h69: r = '{MN_ADC, AM_IMM}; 8'h6A: r = '{MN_ROR, AM_ACC};
      8'h6C: r = '{MN_JMP, AM_AI};  8'h6D: r = '{MN_ADC, AM_AB};
      8'h6E: r = '{MN_ROR, AM_AB};
      8'h70: r = '{MN_BVS, AM_REL}; 8'h71: r = '{MN_ADC, AM_ZIY};
      8'h72: r = '{MN_ADC, AM_ZI};  8'h74: r = '{MN_STZ, AM_ZPX};
      8'h75: r = '{MN_ADC, AM_ZPX}; 8'h76: r = '{MN_ROR, AM_ZPX};
      8'h78: r = '{MN_SEI, AM_IMP}; 8'h79: r = '{MN_ADC, AM_ABY};
      8'h7A: r = '{MN_PLY, AM_IMP}; 8'h7C: r = '{MN_JMP, AM_AIX};
      8'h7D: r = '{MN_ADC, AM_ABX}; 8'h7E: r = '{MN_ROR, AM_ABX};
      8'h80: r = '{MN_BRA, AM_REL}; 8'h81: r = '{MN_STA, AM_ZIX};
      8'h84: r = '{MN_STY, AM_ZP};  8'h85: r = '{MN_STA, AM_ZP};
      8'h86: r = '{MN_STX, AM_ZP};  8'h88: r = '{MN_DEY, AM_IMP};
      8'h89: r = '{MN_BIT, AM_IMM}; 8'h8A: r = '{MN_TXA, AM_IMP};
      8'h8C: r = '{MN_STY, AM_AB};  8'h8D: r = '{MN_STA, AM_AB};
      8'h8E: r = '{MN_STX, AM_AB};
      8'h90: r = '{MN_BCC, AM_REL}; 8'h91: r = '{MN_STA, AM_ZIY};
      8'h92: r = '{MN_STA, AM_ZI};  8'h94: r = '{MN_STY, AM_ZPX};
      8'h95: r = '{MN_STA, AM_ZPX}; 8'h96: r = '{MN_STX, AM_ZPY};
      8'h98: r = '{MN_TYA, AM_IMP}; 8'h99: r = '{MN_STA, AM_ABY};
      8'h9A: r = '{MN_TXS, AM_IMP}; 8'h9C: r = '{MN_STZ, AM_AB};
      8'h9D: r = '{MN_STA, AM_ABX}; 8'h9E: r = '{MN_STZ, AM_ABX};
      8'hA0: r = '{MN_LDY, AM_IMM}; 8'hA1: r = '{MN_LDA, AM_ZIX};
      8'hA2: r = '{MN_LDX, AM_IMM}; 8'hA4: r = '{MN_LDY, AM_ZP};
      8'hA5: r = '{MN_LDA, AM_ZP};  8'hA6: r = '{MN_LDX, AM_ZP};
      8'hA8: r = '{MN_TAY, AM_IMP}; 8'hA9: r = '{MN_LDA, AM_IMM};
      8'hAA: r = '{MN_TAX, AM_IMP}; 8'hAC: r = '{MN_LDY, AM_AB};
      8'hAD: r = '{MN_LDA, AM_AB};  8'hAE: r = '{MN_LDX, AM_AB};
      8'hB0: r = '{MN_BCS, AM_REL}; 8'hB1: r = '{MN_LDA, AM_ZIY};
      8'hB2: r = '{MN_LDA, AM_ZI};  8'hB4: r = '{MN_LDY, AM_ZPX};
      8'hB5: r = '{MN_LDA, AM_ZPX}; 8'hB6: r = '{MN_LDX, AM_ZPY};
      8'hB8: r = '{MN_CLV, AM_IMP}; 8'hB9: r = '{MN_LDA, AM_ABY};
      8'hBA: r = '{MN_TSX, AM_IMP}; 8'hBC: r = '{MN_LDY, AM_ABX};
      8'hBD: r = '{MN_LDA, AM_ABX}; 8'hBE: r = '{MN_LDX, AM_ABY};
      8'hC0: r = '{MN_CPY, AM_IMM}; 8'hC1: r = '{MN_CMP, AM_ZIX};
      8'hC4: r = '{MN_CPY, AM_ZP};  8'hC5: r = '{MN_CMP, AM_ZP};
      8'hC6: r = '{MN_DEC, AM_ZP};  8'hC8: r = '{MN_INY, AM_IMP};
      8'hC9: r = '{MN_CMP, AM_IMM}; 8'hCA: r = '{MN_DEX, AM_IMP};
      8'hCB: r = '{MN_WAI, AM_IMP}; 8'hCC: r = '{MN_CPY, AM_AB};
      8'hCD: r = '{MN_CMP, AM_AB};  8'hCE: r = '{MN_DEC, AM_AB};
      8'hD0: r = '{MN_BNE, AM_REL}; 8'hD1: r = '{MN_CMP, AM_ZIY};
      8'hD2: r = '{MN_CMP, AM_ZI};  8'hD4: r = '{MN_UND, AM_ZP};
      8'hD5: r = '{MN_CMP, AM_ZPX}; 8'hD6: r = '{MN_DEC, AM_ZPX};
      8'hD8: r = '{MN_CLD, AM_IMP}; 8'hD9: r = '{MN_CMP, AM_ABY};
      8'hDA: r = '{MN_PHX, AM_IMP}; 8'hDB: r = '{MN_STP, AM_IMP};
      8'hDC: r = '{MN_UND, AM_AB};  8'hDD: r = '{MN_CMP, AM_ABX};
      8'hDE: r = '{MN_DEC, AM_ABX};
      8'hE0: r = '{MN_CPX, AM_IMM}; 8'hE1: r = '{MN_SBC, AM_ZIX};
      8'hE4: r = '{MN_CPX, AM_ZP};  8'hE5: r = '{MN_SBC, AM_ZP};
      8'hE6: r = '{MN_INC, AM_ZP};  8'hE8: r = '{MN_INX, AM_IMP};
      8'hE9: r = '{MN_SBC, AM_IMM}; 8'hEA: r = '{MN_NOP, AM_IMP};
      8'hEC: r = '{MN_CPX, AM_AB};  8'hED: r = '{MN_SBC, AM_AB};
      8'hEE: r = '{MN_INC, AM_AB};
      8'hF0: r = '{MN_BEQ, AM_REL}; 8'hF1: r = '{MN_SBC, AM_ZIY};
      8'hF2: r = '{MN_SBC, AM_ZI};  8'hF4: r = '{MN_UND, AM_ZP};
      8'hF5: r = '{MN_SBC, AM_ZPX}; 8'hF6: r = '{MN_INC, AM_ZPX};
      8'hF8: r = '{MN_SED, AM_IMP}; 8'hF9: r = '{MN_SBC, AM_ABY};
      8'hFA: r = '{MN_PLX, AM_IMP}; 8'hFC: r = '{MN_UND, AM_AB};
      8'hFD: r = '{MN_SBC, AM_ABX}; 8'hFE: r = '{MN_INC, AM_ABX};
      default: r = '{MN_UND, AM_IMP};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/isp65_stream_if.sv
`default_nettype none
interface isp65_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/isp65_collect.sv
`default_nettype none
module isp65_collect (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output logic                  emit_o,
  output isp65_pkg::out_word_t  word_o
);
  import isp65_pkg::*;

  logic [1:0]  pend_q, pend_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  op_q, op_d;
  logic [7:0]  lo_q, lo_d;
  mode_e       mode_q, mode_d;

  op_info_t    info;
  logic [7:0]  e_op, e_lo, e_hi;
  mode_e       e_mode;
  logic [1:0]  e_len;
  logic [15:0] target;

  assign info = op_lookup(pend_q == 2'd0 ? byte_i : op_q);

  always_comb begin
    pend_d = pend_q;
    addr_d = addr_q;
    op_d   = op_q;
    lo_d   = lo_q;
    mode_d = mode_q;
    emit_o = 1'b0;
    e_op   = op_q;
    e_mode = mode_q;
    e_lo   = 8'd0;
    e_hi   = 8'd0;
    if (pend_q == 2'd0) begin
      e_op   = byte_i;
      e_mode = info.mode;
    end
    e_len = mode_length(e_mode);
    if (step_i) begin
      if (pend_q == 2'd0) begin
        if (e_len == 2'd1) begin
          emit_o = 1'b1;
        end else begin
          op_d   = byte_i;
          mode_d = info.mode;
          lo_d   = 8'd0;
          pend_d = e_len - 2'd1;
        end
      end else if (pend_q == 2'd2) begin
        lo_d   = byte_i;
        pend_d = 2'd1;
      end else begin
        emit_o = 1'b1;
        if (e_len == 2'd3) begin
          e_lo = lo_q;
          e_hi = byte_i;
        end else begin
          e_lo = byte_i;
        end
      end
      if (emit_o) begin
        pend_d = 2'd0;
        addr_d = addr_q + {14'd0, e_len};
      end
    end
    if (cfg_we_i) begin
      addr_d = cfg_wdata_i;
      pend_d = 2'd0;
    end
  end

  assign target = (e_mode == AM_REL)
    ? addr_q + BranchBias + {{8{e_lo[7]}}, e_lo} : 16'd0;

  always_comb begin
    word_o.instr_address = addr_q;
    word_o.opcode        = e_op;
    word_o.mnemonic      = info.mnem;
    word_o.addr_mode     = e_mode;
    word_o.operand_low   = e_lo;
    word_o.operand_high  = e_hi;
    word_o.instr_length  = e_len;
    word_o.branch_target = target;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      addr_q <= 16'd0;
      op_q   <= 8'd0;
      lo_q   <= 8'd0;
      mode_q <= AM_IMP;
    end else begin
      pend_q <= pend_d;
      addr_q <= addr_d;
      op_q   <= op_d;
      lo_q   <= lo_d;
      mode_q <= mode_d;
    end
  end
endmodule
`default_nettype wire

// File: sv/instr_stream_predecoder_65c02_top.sv
// channel | dir | word             | handshake
// in_s    | in  | code byte        | valid/ready
// out_s   | out | instruction rec. | valid/ready
// cfg     | in  | start address    | cfg_we_i, no wait
// one byte accepted per cycle unless the input stalls; a record is valid the cycle after its last byte is taken
// the output register refills in the cycle it is taken, so there are no bubbles
// input stalls only while a record is held and not taken
// reset clears collection state and sets the address to zero
`default_nettype none
module instr_stream_predecoder_65c02_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  isp65_stream_if.sink   in_s,
  isp65_stream_if.source out_s
);
  import isp65_pkg::*;

  logic      step, emit;
  out_word_t rec;
  logic      ov_q;
  out_word_t od_q;

  assign in_s.ready = !ov_q || out_s.ready;
  assign step       = in_s.valid && in_s.ready;

  isp65_collect u_collect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .byte_i      (in_s.data.code_byte),
    .emit_o      (emit),
    .word_o      (rec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (in_s.ready) begin
      ov_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_s.ready && emit) begin
      od_q <= rec;
    end
  end

  assign out_s.valid = ov_q;
  assign out_s.data  = od_q;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_s.ready |=> ov_q && $stable(od_q))
    else $error("held record changed");
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> od_q.instr_length != 2'd0)
    else $error("bad length");
  a_tgt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && od_q.addr_mode != AM_REL |-> od_q.branch_target == 16'd0)
    else $error("stray branch target");
endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
module tb;
  import isp65_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int LongHold = 300;

  // addressing mode per opcode, one nibble each, opcode 0 in the top nibble
  localparam logic [1023:0] ModeTab = {
    64'h070044400310aaa0, 64'h289045500c10abb0, 64'ha70044400310aaa0, 64'h289055500c10bbb0,
    64'h070044400310aaa0, 64'h289045500c00abb0, 64'h070044400310daa0, 64'h289055500c00ebb0,
    64'h270044400300aaa0, 64'h289055600c00abb0, 64'h373044400300aaa0, 64'h289055600c00bbc0,
    64'h370044400300aaa0, 64'h289045500c00abb0, 64'h370044400300aaa0, 64'h289045500c00abb0
  };

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [15:0] cfg_wdata_i;

  isp65_stream_if #(.word_t(in_word_t)) in_if ();
  isp65_stream_if #(.word_t(out_word_t)) out_if ();

  instr_stream_predecoder_65c02_top uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_s(in_if.sink),
    .out_s(out_if.source)
  );

  mnem_e mnem_tab [256];
  out_word_t expected_recs [$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;
  bit hold_req = 0;

  logic [1:0] pend;
  logic [15:0] cur_addr;
  logic [7:0] held_op;
  logic [7:0] held_lo;
  mode_e held_mode;

  initial begin
    mnem_tab = '{
      MN_BRK, MN_ORA, MN_UND, MN_UND, MN_TSB, MN_ORA, MN_ASL, MN_UND,
      MN_PHP, MN_ORA, MN_ASL, MN_UND, MN_TSB, MN_ORA, MN_ASL, MN_UND,
      MN_BPL, MN_ORA, MN_ORA, MN_UND, MN_TRB, MN_ORA, MN_ASL, MN_UND,
      MN_CLC, MN_ORA, MN_INC, MN_UND, MN_TRB, MN_ORA, MN_ASL, MN_UND,
      MN_JSR, MN_AND, MN_UND, MN_UND, MN_BIT, MN_AND, MN_ROL, MN_UND,
      MN_PLP, MN_AND, MN_ROL, MN_UND, MN_BIT, MN_AND, MN_ROL, MN_UND,
      MN_BMI, MN_AND, MN_AND, MN_UND, MN_BIT, MN_AND, MN_ROL, MN_UND,
      MN_SEC, MN_AND, MN_DEC, MN_UND, MN_BIT, MN_AND, MN_ROL, MN_UND,
      MN_RTI, MN_EOR, MN_UND, MN_UND, MN_UND, MN_EOR, MN_LSR, MN_UND,
      MN_PHA, MN_EOR, MN_LSR, MN_UND, MN_JMP, MN_EOR, MN_LSR, MN_UND,
      MN_BVC, MN_EOR, MN_EOR, MN_UND, MN_UND, MN_EOR, MN_LSR, MN_UND,
      MN_CLI, MN_EOR, MN_PHY, MN_UND, MN_UND, MN_EOR, MN_LSR, MN_UND,
      MN_RTS, MN_ADC, MN_UND, MN_UND, MN_STZ, MN_ADC, MN_ROR, MN_UND,
      MN_PLA, MN_ADC, MN_ROR, MN_UND, MN_JMP, MN_ADC, MN_ROR, MN_UND,
      MN_BVS, MN_ADC, MN_ADC, MN_UND, MN_STZ, MN_ADC, MN_ROR, MN_UND,
      MN_SEI, MN_ADC, MN_PLY, MN_UND, MN_JMP, MN_ADC, MN_ROR, MN_UND,
      MN_BRA, MN_STA, MN_UND, MN_UND, MN_STY, MN_STA, MN_STX, MN_UND,
      MN_DEY, MN_BIT, MN_TXA, MN_UND, MN_STY, MN_STA, MN_STX, MN_UND,
      MN_BCC, MN_STA, MN_STA, MN_UND, MN_STY, MN_STA, MN_STX, MN_UND,
      MN_TYA, MN_STA, MN_TXS, MN_UND, MN_STZ, MN_STA, MN_STZ, MN_UND,
      MN_LDY, MN_LDA, MN_LDX, MN_UND, MN_LDY, MN_LDA, MN_LDX, MN_UND,
      MN_TAY, MN_LDA, MN_TAX, MN_UND, MN_LDY, MN_LDA, MN_LDX, MN_UND,
      MN_BCS, MN_LDA, MN_LDA, MN_UND, MN_LDY, MN_LDA, MN_LDX, MN_UND,
      MN_CLV, MN_LDA, MN_TSX, MN_UND, MN_LDY, MN_LDA, MN_LDX, MN_UND,
      MN_CPY, MN_CMP, MN_UND, MN_UND, MN_CPY, MN_CMP, MN_DEC, MN_UND,
      MN_INY, MN_CMP, MN_DEX, MN_WAI, MN_CPY, MN_CMP, MN_DEC, MN_UND,
      MN_BNE, MN_CMP, MN_CMP, MN_UND, MN_UND, MN_CMP, MN_DEC, MN_UND,
      MN_CLD, MN_CMP, MN_PHX, MN_STP, MN_UND, MN_CMP, MN_DEC, MN_UND,
      MN_CPX, MN_SBC, MN_UND, MN_UND, MN_CPX, MN_SBC, MN_INC, MN_UND,
      MN_INX, MN_SBC, MN_NOP, MN_UND, MN_CPX, MN_SBC, MN_INC, MN_UND,
      MN_BEQ, MN_SBC, MN_SBC, MN_UND, MN_UND, MN_SBC, MN_INC, MN_UND,
      MN_SED, MN_SBC, MN_PLX, MN_UND, MN_UND, MN_SBC, MN_INC, MN_UND
    };
  end

  function automatic logic [1:0] bytes_of(mode_e m);
    if (m <= AM_ACC) return 2'd1;
    if (m <= AM_ZI) return 2'd2;
    return 2'd3;
  endfunction

  function automatic void record_instr(logic [7:0] op, mode_e m, logic [7:0] lo,
                                       logic [7:0] hi);
    out_word_t r;
    r.instr_address = cur_addr;
    r.opcode = op;
    r.mnemonic = mnem_tab[op];
    r.addr_mode = m;
    r.operand_low = lo;
    r.operand_high = hi;
    r.instr_length = bytes_of(m);
    r.branch_target = (m == AM_REL) ? cur_addr + 16'd2 + {{8{lo[7]}}, lo} : 16'd0;
    expected_recs.push_back(r);
    cur_addr = cur_addr + 16'(bytes_of(m));
    pend = 2'd0;
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    mode_e m;
    m = mode_e'(ModeTab[1023 - 4 * int'(b) -: 4]);
    if (pend == 2'd0) begin
      if (bytes_of(m) == 2'd1) begin
        record_instr(b, m, 8'h00, 8'h00);
      end else begin
        held_op = b;
        held_mode = m;
        held_lo = 8'h00;
        pend = bytes_of(m) - 2'd1;
      end
    end else if (pend == 2'd2) begin
      held_lo = b;
      pend = 2'd1;
    end else if (bytes_of(held_mode) == 2'd3) begin
      record_instr(held_op, held_mode, held_lo, b);
    end else begin
      record_instr(held_op, held_mode, b, 8'h00);
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver side
  initial begin
    int n;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 6);
      if (hold_req) begin
        hold_req = 0;
        n = LongHold;
      end
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  always @(posedge clk_i) begin
    out_word_t e;
    out_word_t a;
    if (rst_ni && out_if.valid && out_if.ready) begin
      a = out_if.data;
      if (expected_recs.size() == 0) begin
        $error("unexpected word at address %h", a.instr_address);
        errors++;
      end else begin
        e = expected_recs.pop_front();
        if (a !== e) begin
          errors++;
          if (a.instr_address !== e.instr_address)
            $error("instr_address exp %h got %h", e.instr_address, a.instr_address);
          if (a.opcode !== e.opcode) $error("opcode exp %h got %h", e.opcode, a.opcode);
          if (a.mnemonic !== e.mnemonic)
            $error("mnemonic exp %0d got %0d", e.mnemonic, a.mnemonic);
          if (a.addr_mode !== e.addr_mode)
            $error("addr_mode exp %0d got %0d", e.addr_mode, a.addr_mode);
          if (a.operand_low !== e.operand_low)
            $error("operand_low exp %h got %h", e.operand_low, a.operand_low);
          if (a.operand_high !== e.operand_high)
            $error("operand_high exp %h got %h", e.operand_high, a.operand_high);
          if (a.instr_length !== e.instr_length)
            $error("instr_length exp %0d got %0d", e.instr_length, a.instr_length);
          if (a.branch_target !== e.branch_target)
            $error("branch_target exp %h got %h", e.branch_target, a.branch_target);
        end
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    int n;
    n = quiet ? 0 : $urandom_range(0, 6);
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= b;
    do @(posedge clk_i); while (!in_if.ready);
    decode_byte(b);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_recs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_start(logic [15:0] a);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_addr = a;
    pend = 2'd0;
  endtask

  task automatic test_directed();
    logic [7:0] seq [$];
    seq = '{8'h00, 8'h0A, 8'hA9, 8'hFF, 8'h10, 8'h80, 8'hD0, 8'h7F, 8'h4C, 8'h00,
            8'hFF, 8'h6C, 8'h34, 8'h12, 8'h7C, 8'hFF, 8'h00, 8'h02, 8'h44, 8'h55,
            8'h5C, 8'hAA, 8'h55, 8'hFF};
    foreach (seq[i]) send_byte(seq[i]);
    // branch and address wrap near the top
    set_start(16'hFFFE);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'hEA);
    // partial instruction dropped by a start address write
    send_byte(8'h20);
    send_byte(8'h12);
    set_start(16'hFFFF);
    send_byte(8'hF0);
    send_byte(8'h01);
    send_byte(8'h20);
    set_start(16'h0000);
    send_byte(8'hCB);
  endtask

  task automatic test_random();
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: set_start(16'h0000);
        1: set_start(16'hFFFF);
        default: set_start(16'($urandom_range(0, 65535)));
      endcase
      quiet = (p % 4 == 3);
      repeat (160) send_byte(8'($urandom_range(0, 255)));
    end
    quiet = 0;
  endtask

  task automatic test_backpressure();
    set_start(16'h8000);
    hold_req = 1;
    repeat (40) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= 16'h0000;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    pend = 2'd0;
    cur_addr = 16'h0000;
    held_op = 8'h00;
    held_lo = 8'h00;
    held_mode = AM_IMP;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    drain();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
